>>> src/peer_table_with_idle_aging_macros.svh
// ----------------------------------------------------------------------------
// Peer table assertion macros
// Shared concurrent assertion forms for the peer table checker.
// ----------------------------------------------------------------------------
`ifndef PEER_TABLE_WITH_IDLE_AGING_MACROS_SVH
`define PEER_TABLE_WITH_IDLE_AGING_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PTIA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("peer table check failed");

// next-cycle implication, sampled on clk, off during reset
`define PTIA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("peer table check failed");

`endif

>>> src/ptia_pkg.sv
// ----------------------------------------------------------------------------
// Peer table package
// Field widths, codes and the entry record shared by the peer table files.
// ----------------------------------------------------------------------------
package ptia_pkg;

	localparam int unsigned MAX_PEERS_DEF = 16;

	localparam int ADDR_W   = 32;
	localparam int PORT_W   = 16;
	localparam int TIME_W   = 16;
	localparam int SLOT_W   = 4;
	localparam int EVENT_W  = 3;
	localparam int ACTION_W = 2;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [PADDR_W-3:0] REG_TIMEOUT_RELOAD = '0;
	localparam logic [TIME_W-1:0]  RELOAD_RST         = 16'd1000;

	localparam logic [ACTION_W-1:0] ACT_ANNOUNCE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOOKUP   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_IGNORE   = 2'd3;

	localparam logic [EVENT_W-1:0] EV_REFRESHED = 3'd0;
	localparam logic [EVENT_W-1:0] EV_ADDED     = 3'd1;
	localparam logic [EVENT_W-1:0] EV_FULL      = 3'd2;
	localparam logic [EVENT_W-1:0] EV_HIT       = 3'd3;
	localparam logic [EVENT_W-1:0] EV_MISS      = 3'd4;
	localparam logic [EVENT_W-1:0] EV_EXPIRED   = 3'd5;
	localparam logic [EVENT_W-1:0] EV_NONE      = 3'd6;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [PORT_W-1:0] port;
		logic [TIME_W-1:0] remaining;
	} entry_t;

endpackage

>>> src/ptia_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptia_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/peer_table_with_idle_aging.sv
// A new request is stalled (request_stall) while an earlier one scans the slots
// or waits to issue its final result. The slot scan reads one table entry per
// cycle via a single RAM read port, unless result_stall holds an expired result.
// Any request may be held up while a result waits on result_stall.
// Reset empties the table (valid bits cleared) and loads timeout_reload with 1000.
// ----------------------------------------------------------------------------
// Peer table with idle aging
// Keyed peer table scanned by one compare/subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
module peer_table_with_idle_aging #(
	parameter int unsigned MAX_PEERS = ptia_pkg::MAX_PEERS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ptia_pkg::PADDR_W-1:0]    paddr,
	input  logic [ptia_pkg::PDATA_W-1:0]    pwdata,
	output logic [ptia_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	input  logic                            request_valid,
	output logic                            request_stall,
	input  logic [ptia_pkg::ACTION_W-1:0]   action,
	input  logic [ptia_pkg::ADDR_W-1:0]     peer_address,
	input  logic [ptia_pkg::PORT_W-1:0]     peer_port,
	input  logic [ptia_pkg::TIME_W-1:0]     elapsed,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [ptia_pkg::EVENT_W-1:0]    event_res,
	output logic [ptia_pkg::SLOT_W-1:0]     slot,
	output logic [ptia_pkg::ADDR_W-1:0]     found_address,
	output logic [ptia_pkg::PORT_W-1:0]     found_port,
	output logic                            last
);

	import ptia_pkg::*;

	localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PEERS - 1);
	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t                 state_q;
	logic [ACTION_W-1:0]    act_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [PORT_W-1:0]      port_q;
	logic [TIME_W-1:0]      elapsed_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   match_q;
	logic [IDX_W-1:0]       match_slot_q;
	logic                   free_q;
	logic [IDX_W-1:0]       free_slot_q;
	logic                   pend_q;
	logic [IDX_W-1:0]       pend_slot_q;
	logic [ADDR_W-1:0]      pend_addr_q;
	logic [PORT_W-1:0]      pend_port_q;
	logic [MAX_PEERS-1:0]   valid_q;
	logic [TIME_W-1:0]      reload_q;
	logic                   out_valid_q;
	logic [EVENT_W-1:0]     out_event_q;
	logic [SLOT_W-1:0]      out_slot_q;
	logic [ADDR_W-1:0]      out_addr_q;
	logic [PORT_W-1:0]      out_port_q;
	logic                   out_last_q;

	logic                   req_acc;
	logic                   cfg_wr;
	logic                   out_free;
	logic                   is_tick;
	logic                   scan_end;
	logic [IDX_W-1:0]       idx_next;
	logic                   cur_valid;
	logic                   key_hit;
	logic                   expire;
	logic [TIME_W-1:0]      remain_sub;
	logic                   advance;
	logic                   emit_mid;
	logic                   fin_go;
	logic                   add_new;
	entry_t                 rd_entry;
	entry_t                 wr_entry;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [IDX_W-1:0]       rd_addr;
	logic [EVENT_W-1:0]     fin_event;
	logic [IDX_W-1:0]       fin_slot;
	logic                   fin_slot_used;
	logic [ADDR_W-1:0]      fin_addr;
	logic [PORT_W-1:0]      fin_port;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready &
		(paddr[PADDR_W-1:2] == REG_TIMEOUT_RELOAD);
	assign prdata = (paddr[PADDR_W-1:2] == REG_TIMEOUT_RELOAD) ?
		PDATA_W'(reload_q) : '0;

	assign request_stall = (state_q != ST_IDLE);
	assign req_acc       = request_valid & ~request_stall;
	assign out_free      = ~out_valid_q | ~result_stall;

	assign is_tick    = (act_q == ACT_TICK);
	assign scan_end   = is_tick ? (idx_q == '0) : (idx_q == IDX_LAST);
	assign idx_next   = is_tick ? (idx_q - 1'b1) : (idx_q + 1'b1);
	assign cur_valid  = valid_q[idx_q];
	assign key_hit    = cur_valid && (rd_entry.address == addr_q) && (rd_entry.port == port_q);
	assign expire     = cur_valid && (elapsed_q > rd_entry.remaining);
	assign remain_sub = rd_entry.remaining - elapsed_q;

	assign advance  = ~(is_tick && expire && pend_q && ~out_free);
	assign emit_mid = (state_q == ST_SCAN) && is_tick && expire && pend_q && advance;
	assign fin_go   = (state_q == ST_FIN) && out_free;
	assign add_new  = (act_q == ACT_ANNOUNCE) && ~match_q && free_q;

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_entry = '{address: rd_entry.address, port: rd_entry.port, remaining: remain_sub};
		if (state_q == ST_SCAN) begin
			wr_en = is_tick && advance && cur_valid && ~expire;
		end else if (fin_go && (act_q == ACT_ANNOUNCE) && (match_q || free_q)) begin
			wr_en    = 1'b1;
			wr_addr  = match_q ? match_slot_q : free_slot_q;
			wr_entry = '{address: addr_q, port: port_q, remaining: reload_q};
		end
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE: rd_addr = (action == ACT_TICK) ? IDX_LAST : '0;
			ST_SCAN: rd_addr = advance ? idx_next : idx_q;
			default: rd_addr = idx_q;
		endcase
	end

	ptia_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_PEERS)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_entry),
		.raddr (rd_addr),
		.rdata (rd_entry)
	);

	always_comb begin
		fin_event     = EV_NONE;
		fin_slot      = '0;
		fin_slot_used = 1'b0;
		fin_addr      = addr_q;
		fin_port      = port_q;
		priority if (is_tick) begin
			if (pend_q) begin
				fin_event     = EV_EXPIRED;
				fin_slot      = pend_slot_q;
				fin_slot_used = 1'b1;
				fin_addr      = pend_addr_q;
				fin_port      = pend_port_q;
			end
		end else if (act_q == ACT_ANNOUNCE) begin
			if (match_q) begin
				fin_event     = EV_REFRESHED;
				fin_slot      = match_slot_q;
				fin_slot_used = 1'b1;
			end else if (free_q) begin
				fin_event     = EV_ADDED;
				fin_slot      = free_slot_q;
				fin_slot_used = 1'b1;
			end else begin
				fin_event = EV_FULL;
			end
		end else begin
			fin_event     = match_q ? EV_HIT : EV_MISS;
			fin_slot      = match_slot_q;
			fin_slot_used = match_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			pend_q      <= 1'b0;
			valid_q     <= '0;
			reload_q    <= RELOAD_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				reload_q <= pwdata[TIME_W-1:0];
			end
			if (emit_mid || fin_go) begin
				out_valid_q <= 1'b1;
			end else if (~result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && (action != ACT_IGNORE)) begin
						state_q <= ST_SCAN;
						match_q <= 1'b0;
						free_q  <= 1'b0;
						pend_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (advance) begin
						if (scan_end) begin
							state_q <= ST_FIN;
						end
						if (is_tick) begin
							if (expire) begin
								valid_q[idx_q] <= 1'b0;
								pend_q         <= 1'b1;
							end
						end else begin
							if (key_hit && ~match_q) begin
								match_q <= 1'b1;
							end
							if (~cur_valid && ~free_q) begin
								free_q <= 1'b1;
							end
						end
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						if (add_new) begin
							valid_q[free_slot_q] <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			act_q     <= action;
			addr_q    <= peer_address;
			port_q    <= peer_port;
			elapsed_q <= elapsed;
			idx_q     <= (action == ACT_TICK) ? IDX_LAST : '0;
		end else if ((state_q == ST_SCAN) && advance && ~scan_end) begin
			idx_q <= idx_next;
		end
		if ((state_q == ST_SCAN) && ~is_tick) begin
			if (key_hit && ~match_q) begin
				match_slot_q <= idx_q;
			end
			if (~cur_valid && ~free_q) begin
				free_slot_q <= idx_q;
			end
		end
		if ((state_q == ST_SCAN) && is_tick && advance && expire) begin
			pend_slot_q <= idx_q;
			pend_addr_q <= rd_entry.address;
			pend_port_q <= rd_entry.port;
		end
		if (emit_mid) begin
			out_event_q <= EV_EXPIRED;
			out_slot_q  <= SLOT_W'(pend_slot_q);
			out_addr_q  <= pend_addr_q;
			out_port_q  <= pend_port_q;
			out_last_q  <= 1'b0;
		end else if (fin_go) begin
			out_event_q <= fin_event;
			out_slot_q  <= fin_slot_used ? SLOT_W'(fin_slot) : '0;
			out_addr_q  <= fin_addr;
			out_port_q  <= fin_port;
			out_last_q  <= 1'b1;
		end
	end

	assign result_valid  = out_valid_q;
	assign event_res     = out_event_q;
	assign slot          = out_slot_q;
	assign found_address = out_addr_q;
	assign found_port    = out_port_q;
	assign last          = out_last_q;

endmodule

>>> src/ptia_checker.sv
// ----------------------------------------------------------------------------
// Peer table checker
// Port-level assertions on the peer table, bound to the top level.
// ----------------------------------------------------------------------------
`include "peer_table_with_idle_aging_macros.svh"

module ptia_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            request_valid,
	input logic                            request_stall,
	input logic [ptia_pkg::ACTION_W-1:0]   action,
	input logic                            result_valid,
	input logic                            result_stall,
	input logic [ptia_pkg::EVENT_W-1:0]    event_res,
	input logic [ptia_pkg::SLOT_W-1:0]     slot,
	input logic [ptia_pkg::ADDR_W-1:0]     found_address,
	input logic [ptia_pkg::PORT_W-1:0]     found_port,
	input logic                            last
);

	import ptia_pkg::*;

	`PTIA_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(event_res) && $stable(slot) && $stable(found_address) && $stable(found_port) && $stable(last))

	`PTIA_ASSERT_NOW(a_no_slot, result_valid && (event_res == EV_FULL || event_res == EV_MISS || event_res == EV_NONE), slot == '0)

	`PTIA_ASSERT_NOW(a_single_last, result_valid && event_res != EV_EXPIRED, last)

	`PTIA_ASSERT_NEXT(a_busy_after_request, request_valid && !request_stall && action != ACT_IGNORE, request_stall)

endmodule

bind peer_table_with_idle_aging ptia_checker u_ptia_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.request_valid (request_valid),
	.request_stall (request_stall),
	.action        (action),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.event_res     (event_res),
	.slot          (slot),
	.found_address (found_address),
	.found_port    (found_port),
	.last          (last)
);
